// ----- rtl/core/fbpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and control/status types of the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned MIN_BLOCK_BYTES = 8;
  localparam int unsigned MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned GRANULES        = 1024;
  localparam int unsigned GRAN_W          = $clog2(GRANULES);

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned BYTES_W  = 14;
  localparam int unsigned STEP_W   = BYTES_W + 1;
  localparam int unsigned SUM_W    = BYTES_W + 2;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned INDEX_W  = 10;

  localparam logic [COUNT_W-1:0] FREE_LIMIT    = 11'd1024;
  localparam logic [INDEX_W-1:0] LAST_INDEX    = 10'd1023;
  localparam logic [BYTES_W-1:0] ROUNDED_LIMIT = 14'd16383;

  localparam logic [1:0] OP_BUILD   = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd3;

  localparam logic [1:0] CFG_AREA_BASE  = 2'd0;
  localparam logic [1:0] CFG_AREA_BYTES = 2'd1;
  localparam logic [1:0] CFG_REQ_BYTES  = 2'd2;

  typedef struct packed {
    logic latch;
    logic exec;
    logic alloc_upd;
    logic walk;
    logic load_out;
  } fbpa_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       zero_req;
    logic       no_blocks;
    logic       list_empty;
    logic       walk_last;
  } fbpa_stat_t;

endpackage

// ----- rtl/core/fbpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer of the allocator: takes one beat, steps the datapath through the
// operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  fbpa_stat_t stat,
  output fbpa_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == OP_BUILD && !stat.zero_req && !stat.no_blocks) begin
          state_nxt = S_WALK;
        end else if (stat.op == OP_ALLOC && !stat.list_empty) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC: begin
        cmd.alloc_upd = 1'b1;
        state_nxt     = S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/fbpa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath of the allocator: configuration, list head, free count, link
// memory, list build walker and the output register.
// ----------------------------------------------------------------------------
module fbpa_dp import fbpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [ADDR_W-1:0]   cfg_wdata,
  input  logic [1:0]          in_opcode,
  input  logic [ADDR_W-1:0]   in_release_addr,
  input  fbpa_cmd_t           cmd,
  output fbpa_stat_t          stat,
  output logic [1:0]          out_status,
  output logic [ADDR_W-1:0]   out_block_addr,
  output logic [COUNT_W-1:0]  out_free_count
);

  logic [ADDR_W-1:0]  base_r;
  logic [BYTES_W-1:0] area_r;
  logic [BYTES_W-1:0] req_r;

  logic [1:0]         op_r;
  logic [ADDR_W-1:0]  rel_r;
  logic [ADDR_W-1:0]  head_r;
  logic [COUNT_W-1:0] free_r;
  logic [BYTES_W-1:0] rounded_r;
  logic [STEP_W-1:0]  step_r;
  logic [BYTES_W-1:0] off_r;
  logic [INDEX_W-1:0] idx_r;
  logic [1:0]         res_status_r;
  logic [ADDR_W-1:0]  res_addr_r;

  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_block_addr_r;
  logic [COUNT_W-1:0] out_free_count_r;

  logic [ADDR_W-1:0]  link_mem [GRANULES];
  logic [ADDR_W-1:0]  link_rd_r;

  logic [STEP_W-1:0]  exact;
  logic [BYTES_W-1:0] rounded_sat;
  logic               zero_req;
  logic               no_blocks;
  logic [SUM_W-1:0]   next_off;
  logic [SUM_W-1:0]   after_off;
  logic               more;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  walk_link;
  logic               rel_ok;
  logic [ADDR_W:0]    area_end;
  logic               mem_we;
  logic [GRAN_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_wdata;
  logic [COUNT_W-1:0] free_inc;

  // rounding always adds up to one full minimum block
  assign exact = {1'b0, req_r} + STEP_W'(MIN_BLOCK_BYTES)
               - STEP_W'(req_r[MIN_SHIFT-1:0]);
  assign rounded_sat = (exact > {1'b0, ROUNDED_LIMIT}) ? ROUNDED_LIMIT : exact[BYTES_W-1:0];
  assign zero_req    = (req_r == '0);
  assign no_blocks   = (exact > {1'b0, area_r});

  // block at off_r exists; check whether the one after it does too
  assign next_off  = {2'b00, off_r} + {1'b0, step_r};
  assign after_off = next_off + {1'b0, step_r};
  assign more      = (after_off <= {2'b00, area_r}) && (idx_r != LAST_INDEX);
  assign cur_addr  = base_r + ADDR_W'(off_r);
  assign walk_link = more ? (base_r + ADDR_W'(next_off[BYTES_W-1:0])) : '0;

  assign area_end = {1'b0, base_r} + (ADDR_W+1)'(area_r);
  assign rel_ok   = (rel_r >= base_r) && (rel_r[MIN_SHIFT-1:0] == '0)
                  && ({1'b0, rel_r} < area_end);
  assign free_inc = (free_r < FREE_LIMIT) ? free_r + 1'b1 : free_r;

  assign mem_we    = cmd.walk || (cmd.exec && op_r == OP_RELEASE && rel_ok);
  assign mem_waddr = cmd.walk ? cur_addr[MIN_SHIFT +: GRAN_W] : rel_r[MIN_SHIFT +: GRAN_W];
  assign mem_wdata = cmd.walk ? walk_link : head_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rd_r <= link_mem[head_r[MIN_SHIFT +: GRAN_W]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      area_r <= '0;
      req_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AREA_BASE:  base_r <= cfg_wdata;
        CFG_AREA_BYTES: area_r <= cfg_wdata[BYTES_W-1:0];
        CFG_REQ_BYTES:  req_r  <= cfg_wdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      free_r    <= '0;
      rounded_r <= '0;
    end else begin
      if (cmd.exec) begin
        case (op_r)
          OP_BUILD: begin
            if (!zero_req) begin
              rounded_r <= rounded_sat;
              if (no_blocks) begin
                head_r <= '0;
                free_r <= '0;
              end else begin
                head_r <= base_r;
              end
            end
          end
          OP_RELEASE: begin
            if (rel_ok) begin
              head_r <= rel_r;
              free_r <= free_inc;
            end
          end
          default: ;
        endcase
      end
      if (cmd.alloc_upd) begin
        head_r <= link_rd_r;
        free_r <= free_r - 1'b1;
      end
      if (cmd.walk && !more) begin
        free_r <= COUNT_W'(idx_r) + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      rel_r <= in_release_addr;
    end
    if (cmd.exec) begin
      res_status_r <= ST_OK;
      res_addr_r   <= '0;
      case (op_r)
        OP_BUILD: begin
          step_r <= exact;
          off_r  <= '0;
          idx_r  <= '0;
          if (zero_req) begin
            res_status_r <= ST_ZERO_SIZE;
          end
        end
        OP_ALLOC: begin
          if (free_r == '0) begin
            res_status_r <= ST_EMPTY;
          end else begin
            res_addr_r <= head_r;
          end
        end
        OP_RELEASE: begin
          if (!rel_ok) begin
            res_status_r <= ST_BAD_ADDR;
          end
        end
        default: ;
      endcase
    end
    if (cmd.walk && more) begin
      off_r <= next_off[BYTES_W-1:0];
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_status_r     <= res_status_r;
      out_block_addr_r <= res_addr_r;
      out_free_count_r <= free_r;
    end
  end

  assign stat.op         = op_r;
  assign stat.zero_req   = zero_req;
  assign stat.no_blocks  = no_blocks;
  assign stat.list_empty = (free_r == '0);
  assign stat.walk_last  = !more;

  assign out_status     = out_status_r;
  assign out_block_addr = out_block_addr_r;
  assign out_free_count = out_free_count_r;

endmodule

// ----- rtl/core/fixed_block_pool_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// One pool of fixed-size blocks with a LIFO free list; link words are held in
// a granule-indexed memory.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | in_opcode, in_release_addr
//   out_    | output    | out_valid / out_stall| out_status, out_block_addr,
//           |           |                     | out_free_count
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// release, unknown opcode and failed build or alloc: latch, execute, done;
// successful alloc adds a step for the registered link memory read.
// build: the walker writes one link word per cycle, one for each block.
// a result waits in the output register while the next beat is taken.
// synchronous active-low reset; link memory contents stay undefined.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit import fbpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [ADDR_W-1:0]   in_release_addr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [ADDR_W-1:0]   out_block_addr,
  output logic [COUNT_W-1:0]  out_free_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [ADDR_W-1:0]   cfg_wdata
);

  fbpa_cmd_t  cmd;
  fbpa_stat_t stat;

  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fbpa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_release_addr (in_release_addr),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_block_addr  (out_block_addr),
    .out_free_count  (out_free_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.alloc_upd, cmd.walk, cmd.load_out}))
    else $error("more than one sequencer command at once");

  a_free_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_count <= FREE_LIMIT)
    else $error("free count beyond limit");

  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_addr == '0)
    else $error("block address on failed beat");

  a_load_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> $past(cmd.exec) || $past(cmd.alloc_upd) || $past(cmd.walk)
                     || $past(in_stall))
    else $error("result loaded without a finished operation");

endmodule
